FILE: rtl/mkrs_pkg.sv
// ----------------------------------------------------------------------------
// mkrs_pkg
// Shared types and constants for the multi-key record sorter.
// ----------------------------------------------------------------------------
package mkrs_pkg;

	localparam int KEY_W          = 32;
	localparam int KEY_FIELDS     = 4;
	localparam int POS_W          = 6;
	localparam int MAX_RECORDS_DEF = 64;
	localparam int MAX_KEYS_DEF   = 4;

	// cell operations
	localparam logic [1:0] OP_HOLD  = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_SORT  = 2'd2;
	localparam logic [1:0] OP_SHIFT = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic       phase;
	} cell_ctrl_t;

endpackage

FILE: rtl/mkrs_cell.sv
// ----------------------------------------------------------------------------
// mkrs_cell
// One slot of the sorting chain: holds a record and trades it with a neighbor.
// ----------------------------------------------------------------------------
module mkrs_cell
	import mkrs_pkg::*;
#(
	parameter int INDEX   = 0,
	parameter int N_CELLS = MAX_RECORDS_DEF,
	parameter int KS      = KEY_FIELDS,
	parameter int IDX_W   = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic              load_sel,
	input  logic [2:0]        nkeys,
	input  logic [3:0]        desc,
	input  logic [KS*KEY_W-1:0] in_keys,
	input  logic [IDX_W-1:0]  in_idx,
	input  logic [KS*KEY_W-1:0] left_keys,
	input  logic [IDX_W-1:0]  left_idx,
	input  logic              left_valid,
	input  logic              left_swap,
	input  logic [KS*KEY_W-1:0] right_keys,
	input  logic [IDX_W-1:0]  right_idx,
	input  logic              right_valid,
	output logic [KS*KEY_W-1:0] keys,
	output logic [IDX_W-1:0]  idx,
	output logic              valid,
	output logic              swap
);

	localparam logic PARITY = 1'(INDEX % 2);
	localparam bit   FIRST  = (INDEX == 0);
	localparam bit   LAST   = (INDEX == N_CELLS - 1);

	logic [KS*KEY_W-1:0] keys_q, keys_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic                valid_q, valid_d;
	logic                is_left, is_right, right_first;

	assign is_left  = (ctrl.phase == PARITY) && !LAST;
	assign is_right = (ctrl.phase != PARITY) && !FIRST;

	// right record strictly before ours; the first differing key in use wins
	always_comb begin
		logic signed [KEY_W-1:0] a, b;
		right_first = 1'b0;
		for (int k = KS - 1; k >= 0; k--) begin
			a = right_keys[k*KEY_W +: KEY_W];
			b = keys_q[k*KEY_W +: KEY_W];
			if ((3'(k) < nkeys) && (a != b)) begin
				right_first = desc[k] ? (a > b) : (a < b);
			end
		end
	end

	assign swap = is_left && valid_q && right_valid && right_first;

	always_comb begin
		keys_d  = keys_q;
		idx_d   = idx_q;
		valid_d = valid_q;
		unique case (ctrl.op)
			OP_LOAD: begin
				if (load_sel) begin
					keys_d  = in_keys;
					idx_d   = in_idx;
					valid_d = 1'b1;
				end
			end
			OP_SORT: begin
				if (swap) begin
					keys_d  = right_keys;
					idx_d   = right_idx;
					valid_d = right_valid;
				end else if (is_right && left_swap) begin
					keys_d  = left_keys;
					idx_d   = left_idx;
					valid_d = left_valid;
				end
			end
			OP_SHIFT: begin
				keys_d  = right_keys;
				idx_d   = right_idx;
				valid_d = LAST ? 1'b0 : right_valid;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		keys_q <= keys_d;
		idx_q  <= idx_d;
	end

	assign keys  = keys_q;
	assign idx   = idx_q;
	assign valid = valid_q;

endmodule

FILE: rtl/multi_key_record_sorter.sv
// ----------------------------------------------------------------------------
// multi_key_record_sorter
// Collects a batch of records and returns their arrival positions in
// stable lexicographic order over up to four signed keys.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tdata = key_first..key_fourth, tlast = batch_end
//  m_*       out        tdata = arrival_position, tlast = final_result,
//                       tuser = overflow
//  APB       in/out     reg 0 key_count @0x0, reg 1 descending_mask @0x4
//
// Records load one per cycle into a chain of MAX_RECORDS cells.
// After the batch-end request the chain runs n odd-even exchange passes,
// one per cycle, n being the records stored; then results leave one per
// cycle from the head of the chain while the output accepts them.
// Input is held off during sorting and emission; a stalled result waits in
// the output register. Reset empties the chain and restores the registers.
// ----------------------------------------------------------------------------
module multi_key_record_sorter
	import mkrs_pkg::*;
#(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF,
	parameter int MAX_KEYS    = MAX_KEYS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // key_first, key_second, key_third, key_fourth
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,   // arrival_position, zero fill
	output logic         m_tlast,
	output logic         m_tuser,   // overflow
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int KS    = (MAX_KEYS < KEY_FIELDS) ? MAX_KEYS : KEY_FIELDS;
	localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	localparam logic REG_KEY_COUNT = 1'b0;
	localparam logic REG_DESC_MASK = 1'b1;

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [2:0]       key_count_q;
	logic [3:0]       desc_mask_q;
	logic [2:0]       nkeys;
	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pass_q;
	logic             dropped_q;
	logic             m_tvalid_q, m_last_q, m_ovf_q;
	logic [POS_W-1:0] m_pos_q;
	logic             s_fire, room, emit_go;
	cell_ctrl_t       ctrl;

	logic [KS*KEY_W-1:0] cell_keys  [MAX_RECORDS];
	logic [IDX_W-1:0]    cell_idx   [MAX_RECORDS];
	logic [MAX_RECORDS-1:0] cell_valid;
	logic [MAX_RECORDS-1:0] cell_swap;
	logic [IDX_W+POS_W-1:0] pos_wide;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= 3'd1;
			desc_mask_q <= 4'd0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_KEY_COUNT: key_count_q <= pwdata[2:0];
				REG_DESC_MASK: desc_mask_q <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_KEY_COUNT: prdata = {29'd0, key_count_q};
			REG_DESC_MASK: prdata = {28'd0, desc_mask_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign nkeys = (32'(key_count_q) > KS) ? 3'(KS) : key_count_q;

	// control
	assign s_tready = (state_q == ST_LOAD);
	assign s_fire   = s_tvalid && s_tready;
	assign room     = (count_q < CNT_W'(MAX_RECORDS));
	assign emit_go  = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	always_comb begin
		ctrl.phase = pass_q[0];
		if (s_fire && room) begin
			ctrl.op = OP_LOAD;
		end else if (state_q == ST_SORT) begin
			ctrl.op = OP_SORT;
		end else if (emit_go) begin
			ctrl.op = OP_SHIFT;
		end else begin
			ctrl.op = OP_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			pass_q    <= '0;
			dropped_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (s_fire) begin
						if (room) begin
							count_q <= count_q + 1'b1;
						end else begin
							dropped_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_SORT;
							pass_q  <= '0;
						end
					end
				end
				ST_SORT: begin
					// n passes settle n records
					if (pass_q + 1'b1 >= count_q) begin
						state_q <= ST_EMIT;
					end else begin
						pass_q <= pass_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						count_q <= count_q - 1'b1;
						if (count_q == CNT_W'(1)) begin
							state_q   <= ST_LOAD;
							dropped_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// output register
	assign pos_wide = {{POS_W{1'b0}}, cell_idx[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			m_pos_q  <= pos_wide[POS_W-1:0];
			m_last_q <= (count_q == CNT_W'(1));
			m_ovf_q  <= dropped_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, m_pos_q};
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_ovf_q;

	// cell chain
	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		logic [KS*KEY_W-1:0] l_keys, r_keys;
		logic [IDX_W-1:0]    l_idx, r_idx;
		logic                l_valid, r_valid, l_swap;

		if (i == 0) begin : g_head
			assign l_keys  = '0;
			assign l_idx   = '0;
			assign l_valid = 1'b0;
			assign l_swap  = 1'b0;
		end else begin : g_mid
			assign l_keys  = cell_keys[i-1];
			assign l_idx   = cell_idx[i-1];
			assign l_valid = cell_valid[i-1];
			assign l_swap  = cell_swap[i-1];
		end

		if (i == MAX_RECORDS - 1) begin : g_tail
			assign r_keys  = '0;
			assign r_idx   = '0;
			assign r_valid = 1'b0;
		end else begin : g_body
			assign r_keys  = cell_keys[i+1];
			assign r_idx   = cell_idx[i+1];
			assign r_valid = cell_valid[i+1];
		end

		mkrs_cell #(
			.INDEX   (i),
			.N_CELLS (MAX_RECORDS),
			.KS      (KS),
			.IDX_W   (IDX_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.load_sel    (count_q == CNT_W'(i)),
			.nkeys       (nkeys),
			.desc        (desc_mask_q),
			.in_keys     (s_tdata[KS*KEY_W-1:0]),
			.in_idx      (count_q[IDX_W-1:0]),
			.left_keys   (l_keys),
			.left_idx    (l_idx),
			.left_valid  (l_valid),
			.left_swap   (l_swap),
			.right_keys  (r_keys),
			.right_idx   (r_idx),
			.right_valid (r_valid),
			.keys        (cell_keys[i]),
			.idx         (cell_idx[i]),
			.valid       (cell_valid[i]),
			.swap        (cell_swap[i])
		);
	end

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RECORDS))
		else $error("record count beyond capacity");

	a_sort_keeps_records: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT) |-> ($countones(cell_valid) == 32'(count_q)))
		else $error("exchange pass lost or duplicated a record");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> cell_valid[0])
		else $error("emitting from an empty chain head");

	a_last_leaves_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && count_q == CNT_W'(1)) |=> (state_q == ST_LOAD && !dropped_q))
		else $error("batch did not close after its final result");

endmodule
